[hw/rtl/kcp_pkg.sv]
// Shared types, constants and reset values for the keyed config port block.
package kcp_pkg;

  localparam int unsigned NUM_SETTINGS = 15;
  localparam int unsigned IDX_W        = 4;

  localparam logic [15:0] KEY_PORT_A = 16'h02FA;
  localparam logic [15:0] KEY_PORT_B = 16'h03FA;
  localparam logic [7:0]  KEY_MAGIC  = 8'h36;
  localparam logic [7:0]  KEY_SUM    = 8'hFF;
  localparam logic [7:0]  RD_IDLE    = 8'hFF;

  // Index that reads back the window address and closes config mode on a data write.
  localparam logic [IDX_W-1:0] EXIT_INDEX = 4'hF;

  // Setting byte indexes that feed the decoded outputs.
  localparam logic [IDX_W-1:0] REG_CTRL  = 4'd0;
  localparam logic [IDX_W-1:0] REG_UART  = 4'd4;
  localparam logic [IDX_W-1:0] REG_PAR   = 4'd6;
  localparam logic [IDX_W-1:0] REG_DRV   = 4'd12;
  localparam logic [IDX_W-1:0] REG_MOUSE = 4'd13;

  typedef logic [NUM_SETTINGS-1:0][7:0] kcp_bank_t;

  // Entry 14 first, entry 0 last.
  localparam kcp_bank_t SETTING_INIT = {
    8'h00, 8'h00, 8'hA0, 8'h00, 8'h00, 8'hB0, 8'h00, 8'h00,
    8'h9E, 8'h00, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h0C
  };

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_KEYED,
    STEP_CHECKED,
    STEP_MAGIC,
    STEP_ADDR
  } kcp_step_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] port;
    logic [7:0]  write_data;
  } kcp_req_t;

  // Window state as seen by the current request, after the unlock sequencer.
  typedef struct packed {
    logic       unlocked;
    logic [7:0] code;
  } kcp_win_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       config_active;
    logic       uart_enable;
    logic [9:0] uart_base;
    logic       parallel_enable;
    logic [9:0] parallel_base;
    logic       ide_enable;
    logic       fdc_enable;
    logic       mouse_enable;
    logic [9:0] mouse_base;
  } kcp_rsp_t;

endpackage

[hw/rtl/kcp_req_if.sv]
// Request channel: one I/O bus access.
interface kcp_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] port;
  logic [7:0]  write_data;

  modport source (output valid, output mode, output port, output write_data, input ready);
  modport sink   (input valid, input mode, input port, input write_data, output ready);
endinterface

[hw/rtl/kcp_rsp_if.sv]
// Result channel: read data and decoded peripheral settings.
interface kcp_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       config_active;
  logic       uart_enable;
  logic [9:0] uart_base;
  logic       parallel_enable;
  logic [9:0] parallel_base;
  logic       ide_enable;
  logic       fdc_enable;
  logic       mouse_enable;
  logic [9:0] mouse_base;

  modport source (
    output valid, output read_data, output config_active, output uart_enable,
    output uart_base, output parallel_enable, output parallel_base, output ide_enable,
    output fdc_enable, output mouse_enable, output mouse_base, input ready
  );
  modport sink (
    input valid, input read_data, input config_active, input uart_enable,
    input uart_base, input parallel_enable, input parallel_base, input ide_enable,
    input fdc_enable, input mouse_enable, input mouse_base, output ready
  );
endinterface

[hw/rtl/keyed_config_port_register_file_core.sv]
// Path: input register, then output register; a stalled result holds the request
// in the input register. Throughput: one request per cycle unless the result stalls;
// the state update for a request happens in the same cycle it leaves the input
// register, so the next one follows directly.
// Reset (rst_n low, synchronous): sequencer idle, locked, window code and index 0,
// setting bytes back to their power-on values, both pipeline stages empty.
module keyed_config_port_register_file_core
  import kcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  kcp_req_if.sink     in_req,
  kcp_rsp_if.source   out_rsp
);

  kcp_req_t req_r;
  logic     req_vld_r;
  kcp_rsp_t rsp_r, rsp_nxt;
  logic     rsp_vld_r;
  logic     pipe_adv, fire;
  logic     exit_cfg;
  kcp_win_t win;

  assign pipe_adv     = !rsp_vld_r || out_rsp.ready;
  assign fire         = req_vld_r && pipe_adv;
  assign in_req.ready = !req_vld_r || pipe_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_req.ready) begin
      req_vld_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_r.mode       <= in_req.mode;
      req_r.port       <= in_req.port;
      req_r.write_data <= in_req.write_data;
    end
  end

  kcp_unlock u_unlock (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .req      (req_r),
    .exit_cfg (exit_cfg),
    .win      (win)
  );

  kcp_regfile u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .req      (req_r),
    .win      (win),
    .exit_cfg (exit_cfg),
    .rsp      (rsp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_vld_r <= 1'b0;
    end else if (pipe_adv) begin
      rsp_vld_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_rsp.valid           = rsp_vld_r;
  assign out_rsp.read_data       = rsp_r.read_data;
  assign out_rsp.config_active   = rsp_r.config_active;
  assign out_rsp.uart_enable     = rsp_r.uart_enable;
  assign out_rsp.uart_base       = rsp_r.uart_base;
  assign out_rsp.parallel_enable = rsp_r.parallel_enable;
  assign out_rsp.parallel_base   = rsp_r.parallel_base;
  assign out_rsp.ide_enable      = rsp_r.ide_enable;
  assign out_rsp.fdc_enable      = rsp_r.fdc_enable;
  assign out_rsp.mouse_enable    = rsp_r.mouse_enable;
  assign out_rsp.mouse_base      = rsp_r.mouse_base;

`ifndef SYNTHESIS
  // A locked result can only carry idle read data.
  a_locked_idle_read: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_vld_r && !rsp_r.config_active |-> rsp_r.read_data == RD_IDLE)
    else $error("read data returned while config mode is closed");

  // A stalled request stays in the input register.
  a_req_held: assert property (@(posedge clk) disable iff (!rst_n)
    req_vld_r && !pipe_adv |=> req_vld_r)
    else $error("pending request dropped under back-pressure");

  // Config mode only opens on a processed write.
  a_open_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !req_r.mode |=> rsp_r.config_active == $past(rsp_nxt.config_active))
    else $error("config mode changed by a read");
`endif

endmodule

[hw/rtl/kcp_unlock.sv]
// Unlock sequencer: key steps, window address code and unlocked flag.
module kcp_unlock
  import kcp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  kcp_req_t req,
  input  logic     exit_cfg,
  output kcp_win_t win
);

  kcp_step_t  step_r, step_nxt;
  logic [7:0] exp_r, exp_nxt;
  logic [7:0] code_r, code_nxt;
  logic       unlocked_r, unl_nxt;
  logic       wr, is_a, is_b;
  logic [7:0] key_sum;

  assign wr      = fire && req.mode;
  assign is_a    = (req.port == KEY_PORT_A);
  assign is_b    = (req.port == KEY_PORT_B);
  assign key_sum = 8'(code_r + req.write_data);

  // Any write that is not the expected step drops back to idle.
  always_comb begin
    step_nxt = step_r;
    if (wr) begin
      step_nxt = STEP_IDLE;
      unique case (step_r)
        STEP_IDLE:    if (is_a) step_nxt = STEP_KEYED;
        STEP_KEYED:   if (is_b && req.write_data == exp_r) step_nxt = STEP_CHECKED;
        STEP_CHECKED: if (is_b && req.write_data == KEY_MAGIC) step_nxt = STEP_MAGIC;
        STEP_MAGIC:   if (is_b) step_nxt = STEP_ADDR;
        STEP_ADDR:    step_nxt = STEP_IDLE;
        default:      step_nxt = STEP_IDLE;
      endcase
    end
  end

  always_comb begin
    exp_nxt  = exp_r;
    code_nxt = code_r;
    unl_nxt  = unlocked_r;
    if (wr) begin
      unique case (step_r)
        STEP_IDLE:    if (is_a) exp_nxt = ~req.write_data;
        STEP_MAGIC:   if (is_b) code_nxt = req.write_data;
        // Final key byte either opens or closes config mode.
        STEP_ADDR:    if (is_a) unl_nxt = (key_sum == KEY_SUM);
        default:      ;
      endcase
    end
  end

  assign win.unlocked = unl_nxt;
  assign win.code     = code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= STEP_IDLE;
      exp_r      <= '0;
      code_r     <= '0;
      unlocked_r <= 1'b0;
    end else if (fire) begin
      step_r     <= step_nxt;
      exp_r      <= exp_nxt;
      code_r     <= code_nxt;
      unlocked_r <= unl_nxt && !exit_cfg;
    end
  end

endmodule

[hw/rtl/kcp_regfile.sv]
// Setting byte file behind the index/data window, read mux and output decode.
module kcp_regfile
  import kcp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  kcp_req_t req,
  input  kcp_win_t win,
  output logic     exit_cfg,
  output kcp_rsp_t rsp
);

  kcp_bank_t        bank_r, bank_nxt;
  logic [IDX_W-1:0] sel_r, sel_nxt;
  logic             idx_hit, data_hit;
  logic [7:0]       rd;
  logic [7:0]       r_ctrl, r_drv, r_mouse;

  assign idx_hit  = (req.port == {6'd0, win.code, 2'b00});
  assign data_hit = (req.port == {6'd0, win.code, 2'b01});

  always_comb begin
    bank_nxt = bank_r;
    sel_nxt  = sel_r;
    exit_cfg = 1'b0;
    if (fire && req.mode && win.unlocked) begin
      if (idx_hit) begin
        sel_nxt = req.write_data[IDX_W-1:0];
      end else if (data_hit) begin
        if (sel_r == EXIT_INDEX) begin
          exit_cfg = 1'b1;
        end else begin
          bank_nxt[sel_r] = req.write_data;
        end
      end
    end
  end

  always_comb begin
    rd = RD_IDLE;
    if (!req.mode && win.unlocked) begin
      if (idx_hit) begin
        rd = {4'd0, sel_r};
      end else if (data_hit) begin
        rd = (sel_r == EXIT_INDEX) ? win.code : bank_r[sel_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= SETTING_INIT;
      sel_r  <= '0;
    end else if (fire) begin
      bank_r <= bank_nxt;
      sel_r  <= sel_nxt;
    end
  end

  // Decoded outputs reflect the settings after this access.
  assign r_ctrl  = bank_nxt[REG_CTRL];
  assign r_drv   = bank_nxt[REG_DRV];
  assign r_mouse = bank_nxt[REG_MOUSE];

  assign rsp.read_data       = rd;
  assign rsp.config_active   = win.unlocked && !exit_cfg;
  assign rsp.uart_enable     = r_ctrl[2];
  assign rsp.uart_base       = {bank_nxt[REG_UART], 2'b00};
  assign rsp.parallel_enable = r_ctrl[3];
  assign rsp.parallel_base   = {bank_nxt[REG_PAR], 2'b00};
  assign rsp.ide_enable      = r_drv[7] && !r_drv[6];
  assign rsp.fdc_enable      = r_drv[5];
  assign rsp.mouse_enable    = (r_mouse != 8'd0);
  assign rsp.mouse_base      = {r_mouse, 2'b00};

endmodule

[tb/tb_keyed_config_port_register_file_core.sv]
// Self-checking testbench for the keyed config port register file core.
module tb_keyed_config_port_register_file_core;
  import kcp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ACCESSES = 1400;
  localparam int unsigned DRAIN_EVERY     = 350;
  localparam int unsigned CYCLE_LIMIT     = 300000;
  localparam int unsigned MAX_REPORTS     = 40;

  typedef struct {
    kcp_req_t req;
    bit       drain;  // hold this request until every result so far is back
  } bus_access_t;

  logic clk = 1'b0;
  logic rst_n;

  kcp_req_if in_req ();
  kcp_rsp_if out_rsp ();

  keyed_config_port_register_file_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  always #2 clk = ~clk;

  // Shadow of the block state
  kcp_step_t  seq_step;
  logic [7:0] key_complement;
  logic [7:0] win_code;
  logic       cfg_open;
  logic [3:0] sel_index;
  kcp_bank_t  setting_bank;

  bus_access_t pending_accesses[$];
  kcp_rsp_t    expected_rsps[$];
  bit          drain_next;
  int unsigned queued_cnt;
  int unsigned accepted_cnt;
  int unsigned returned_cnt;
  int unsigned mismatch_cnt;
  int unsigned open_cnt;
  int unsigned exit_cnt;
  int unsigned read_cnt;
  int unsigned cycle_cnt;

  // Applies one bus access to the shadow state and returns the result it should produce.
  function automatic kcp_rsp_t predict_access(kcp_req_t r);
    kcp_rsp_t   rsp;
    logic       advance;
    logic       was_open;
    logic [15:0] index_port;
    logic [15:0] data_port;
    rsp = '0;
    rsp.read_data = RD_IDLE;
    was_open = cfg_open;
    if (r.mode) begin
      advance = 1'b0;
      if (r.port == KEY_PORT_A) begin
        if (seq_step == STEP_IDLE) begin
          key_complement = ~r.write_data;
          advance = 1'b1;
        end else if (seq_step == STEP_ADDR) begin
          cfg_open = (8'(win_code + r.write_data) == KEY_SUM);
        end
      end else if (r.port == KEY_PORT_B) begin
        if (seq_step == STEP_KEYED && r.write_data == key_complement) begin
          advance = 1'b1;
        end else if (seq_step == STEP_CHECKED && r.write_data == KEY_MAGIC) begin
          advance = 1'b1;
        end else if (seq_step == STEP_MAGIC) begin
          win_code = r.write_data;
          advance = 1'b1;
        end
      end
      // window follows a new address byte immediately
      index_port = {6'b0, win_code, 2'b00};
      data_port  = {6'b0, win_code, 2'b01};
      if (cfg_open) begin
        if (r.port == index_port) begin
          sel_index = r.write_data[3:0];
        end else if (r.port == data_port) begin
          if (sel_index == EXIT_INDEX) begin
            cfg_open = 1'b0;
            exit_cnt++;
          end else begin
            setting_bank[sel_index] = r.write_data;
          end
        end
      end
      seq_step = advance ? kcp_step_t'(seq_step + 3'd1) : STEP_IDLE;
    end else begin
      index_port = {6'b0, win_code, 2'b00};
      data_port  = {6'b0, win_code, 2'b01};
      if (cfg_open) begin
        if (r.port == index_port) begin
          rsp.read_data = {4'b0, sel_index};
        end else if (r.port == data_port) begin
          rsp.read_data = (sel_index == EXIT_INDEX) ? win_code : setting_bank[sel_index];
        end
        if (r.port == index_port || r.port == data_port) read_cnt++;
      end
    end
    if (cfg_open && !was_open) open_cnt++;
    rsp.config_active   = cfg_open;
    rsp.uart_enable     = setting_bank[REG_CTRL][2];
    rsp.uart_base       = {setting_bank[REG_UART], 2'b00};
    rsp.parallel_enable = setting_bank[REG_CTRL][3];
    rsp.parallel_base   = {setting_bank[REG_PAR], 2'b00};
    rsp.ide_enable      = setting_bank[REG_DRV][7] & ~setting_bank[REG_DRV][6];
    rsp.fdc_enable      = setting_bank[REG_DRV][5];
    rsp.mouse_enable    = |setting_bank[REG_MOUSE];
    rsp.mouse_base      = {setting_bank[REG_MOUSE], 2'b00};
    return rsp;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  task automatic check_result(kcp_rsp_t got, kcp_rsp_t want);
    if (got.read_data !== want.read_data)
      flag_mismatch("read_data", got.read_data, want.read_data);
    if (got.config_active !== want.config_active)
      flag_mismatch("config_active", got.config_active, want.config_active);
    if (got.uart_enable !== want.uart_enable)
      flag_mismatch("uart_enable", got.uart_enable, want.uart_enable);
    if (got.uart_base !== want.uart_base)
      flag_mismatch("uart_base", got.uart_base, want.uart_base);
    if (got.parallel_enable !== want.parallel_enable)
      flag_mismatch("parallel_enable", got.parallel_enable, want.parallel_enable);
    if (got.parallel_base !== want.parallel_base)
      flag_mismatch("parallel_base", got.parallel_base, want.parallel_base);
    if (got.ide_enable !== want.ide_enable)
      flag_mismatch("ide_enable", got.ide_enable, want.ide_enable);
    if (got.fdc_enable !== want.fdc_enable)
      flag_mismatch("fdc_enable", got.fdc_enable, want.fdc_enable);
    if (got.mouse_enable !== want.mouse_enable)
      flag_mismatch("mouse_enable", got.mouse_enable, want.mouse_enable);
    if (got.mouse_base !== want.mouse_base)
      flag_mismatch("mouse_base", got.mouse_base, want.mouse_base);
  endtask

  // Mostly short gaps, a few long ones, and now and then a run with none.
  task automatic draw_gap(inout int unsigned calm, output int unsigned gap);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if (roll < 3) begin
      calm = $urandom_range(30, 120);
      gap = 0;
    end else if (roll < 60) begin
      gap = 0;
    end else if (roll < 93) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
  endtask

  task automatic queue_access(logic mode, logic [15:0] port, logic [7:0] data);
    bus_access_t a;
    a.req.mode       = mode;
    a.req.port       = port;
    a.req.write_data = data;
    a.drain          = drain_next;
    drain_next       = 1'b0;
    pending_accesses.push_back(a);
    queued_cnt++;
  endtask

  // spoil: 0 clean, 1 bad complement, 2 bad magic, 3 stray write, 4 harmless read inside
  task automatic queue_key_sequence(logic [7:0] code, logic [7:0] closing, int unsigned spoil);
    logic [7:0]  key;
    logic [7:0]  seq_data [5];
    logic [15:0] seq_port [5];
    key = 8'($urandom);
    seq_port = '{KEY_PORT_A, KEY_PORT_B, KEY_PORT_B, KEY_PORT_B, KEY_PORT_A};
    seq_data = '{key, ~key, KEY_MAGIC, code, closing};
    if (spoil == 1 || spoil == 2)
      seq_data[spoil] = seq_data[spoil] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < 5; i++) begin
      if (spoil == 3 && i == 2) queue_access(1'b1, 16'($urandom), 8'($urandom));
      if (spoil == 4 && i == 3) queue_access(1'b0, 16'($urandom), 8'($urandom));
      queue_access(1'b1, seq_port[i], seq_data[i]);
    end
  endtask

  task automatic queue_window_access(logic [7:0] code);
    logic [15:0] index_port;
    int unsigned roll;
    index_port = {6'b0, code, 2'b00};
    roll = $urandom_range(0, 9);
    if (roll < 3)
      queue_access(1'b1, index_port, {4'($urandom), 4'($urandom_range(0, 15))});
    else if (roll < 6)
      queue_access(1'b1, index_port + 16'd1, 8'($urandom));
    else if (roll < 8)
      queue_access(1'b0, index_port + 16'd1, 8'($urandom));
    else if (roll < 9)
      queue_access(1'b0, index_port, 8'($urandom));
    else
      queue_access(1'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic queue_session();
    logic [7:0]  code;
    logic [7:0]  closing;
    int unsigned roll;
    int unsigned spoil;
    code    = 8'($urandom);
    closing = 8'(KEY_SUM - code);
    if ($urandom_range(0, 9) == 0) closing = 8'($urandom);
    roll  = $urandom_range(0, 11);
    spoil = (roll < 8) ? 0 : roll - 7;
    queue_key_sequence(code, closing, spoil);
    repeat ($urandom_range(1, 12)) queue_window_access(code);
    roll = $urandom_range(0, 9);
    if (roll < 8) begin
      if (roll >= 6) queue_access(1'b0, {6'b0, code, 2'b01}, 8'($urandom));
      if (roll < 7) begin
        queue_access(1'b1, {6'b0, code, 2'b00}, {4'($urandom), EXIT_INDEX});
        queue_access(1'b1, {6'b0, code, 2'b01}, 8'($urandom));
      end
    end
  endtask

  // Request driver
  int unsigned send_gap;
  int unsigned send_calm;
  always @(posedge clk) begin
    int unsigned g;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
      send_gap = 0;
      send_calm = 0;
    end else if (!in_req.valid || in_req.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_req.valid <= 1'b0;
      end else if (pending_accesses.size() == 0 ||
                   (pending_accesses[0].drain &&
                    (in_req.valid || accepted_cnt != returned_cnt))) begin
        in_req.valid <= 1'b0;
      end else begin
        in_req.valid      <= 1'b1;
        in_req.mode       <= pending_accesses[0].req.mode;
        in_req.port       <= pending_accesses[0].req.port;
        in_req.write_data <= pending_accesses[0].req.write_data;
        void'(pending_accesses.pop_front());
        draw_gap(send_calm, g);
        send_gap = g;
      end
    end
  end

  // Result-side backpressure
  int unsigned stall_left;
  int unsigned stall_calm;
  always @(posedge clk) begin
    int unsigned g;
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
      stall_left = 0;
      stall_calm = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= 1'b1;
      draw_gap(stall_calm, g);
      stall_left = g;
    end
  end

  // Monitor: predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    kcp_req_t r;
    kcp_rsp_t got;
    if (rst_n) begin
      if (in_req.valid && in_req.ready) begin
        r.mode       = in_req.mode;
        r.port       = in_req.port;
        r.write_data = in_req.write_data;
        expected_rsps.push_back(predict_access(r));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_rsp.valid && out_rsp.ready) begin
        got.read_data       = out_rsp.read_data;
        got.config_active   = out_rsp.config_active;
        got.uart_enable     = out_rsp.uart_enable;
        got.uart_base       = out_rsp.uart_base;
        got.parallel_enable = out_rsp.parallel_enable;
        got.parallel_base   = out_rsp.parallel_base;
        got.ide_enable      = out_rsp.ide_enable;
        got.fdc_enable      = out_rsp.fdc_enable;
        got.mouse_enable    = out_rsp.mouse_enable;
        got.mouse_base      = out_rsp.mouse_base;
        returned_cnt <= returned_cnt + 1;
        if (expected_rsps.size() == 0)
          flag_mismatch("unexpected result, read_data", got.read_data, 0);
        else
          check_result(got, expected_rsps.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d requests returned",
               cycle_cnt, returned_cnt, queued_cnt);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_req.valid       = 1'b0;
    in_req.mode        = 1'b0;
    in_req.port        = '0;
    in_req.write_data  = '0;
    out_rsp.ready      = 1'b0;
    seq_step           = STEP_IDLE;
    key_complement     = '0;
    win_code           = '0;
    cfg_open           = 1'b0;
    sel_index          = '0;
    setting_bank       = SETTING_INIT;
    drain_next         = 1'b0;
    queued_cnt         = 0;
    accepted_cnt       = 0;
    returned_cnt       = 0;
    mismatch_cnt       = 0;
    open_cnt           = 0;
    exit_cnt           = 0;
    read_cnt           = 0;
    cycle_cnt          = 0;

    // Directed: locked reads, noise, window at the lowest and highest codes
    queue_access(1'b0, 16'h0000, 8'h00);
    queue_access(1'b0, 16'h0001, 8'hFF);
    queue_access(1'b1, 16'hFFFF, 8'hFF);
    queue_key_sequence(8'h00, 8'hFF, 0);
    queue_access(1'b0, 16'h0000, 8'h00);
    queue_access(1'b0, 16'h0001, 8'h00);
    queue_access(1'b1, 16'h0000, 8'hFD);   // upper nibble dropped, selects 13
    queue_access(1'b1, 16'h0001, 8'hFF);
    queue_access(1'b0, 16'h0001, 8'h00);
    queue_access(1'b1, 16'h0000, 8'h0F);
    queue_access(1'b0, 16'h0001, 8'h00);   // reads back the address byte
    queue_access(1'b1, 16'h0001, 8'h00);   // leaves config mode
    queue_access(1'b0, 16'h0001, 8'h00);
    queue_access(1'b1, KEY_PORT_A, 8'h00);
    queue_access(1'b1, KEY_PORT_B, 8'h00); // wrong complement restarts
    queue_key_sequence(8'hFF, 8'h00, 0);
    queue_access(1'b0, 16'h03FD, 8'h00);
    // rekey while open: window moves on the fourth key write, bad closing byte locks
    queue_key_sequence(8'h40, 8'h00, 0);
    drain_next = 1'b1;

    while (queued_cnt < RANDOM_ACCESSES + 25) begin
      if (queued_cnt % DRAIN_EVERY < 6) drain_next = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 3) == 0)
          queue_access(1'($urandom), $urandom_range(0, 1) ? KEY_PORT_A : KEY_PORT_B,
                       8'($urandom));
        else
          queue_access(1'($urandom), 16'($urandom), 8'($urandom));
      end else begin
        queue_session();
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt != queued_cnt) @(posedge clk);
    while (returned_cnt != accepted_cnt) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_rsps.size() != 0)
      flag_mismatch("results still outstanding", expected_rsps.size(), 0);

    $display("covered %0d bus accesses: %0d unlocks, %0d exits through index 15,",
             accepted_cnt, open_cnt, exit_cnt);
    $display("%0d decoded window reads, %0d mismatches", read_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
